[sv/otsu_pkg.sv]
// Shared types, widths and command codes for the tile Otsu threshold binarizer.
// Used by every module of the block; depends on nothing.
package otsu_pkg;

	// Tile geometry and gray scale.
	localparam int TILE_SIDE   = 64;
	localparam int GRAY_LEVELS = 256;
	localparam int LVL_W       = $clog2(GRAY_LEVELS);
	localparam int BIN_W       = 13;
	localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

	// Widths of the class sums: pixel count, first and second moments.
	// The count covers every bin at its saturated maximum.
	localparam int CNT_W  = BIN_W + LVL_W;
	localparam int SQ_W   = 2 * LVL_W;
	localparam int S1_W   = CNT_W + LVL_W;
	localparam int S2_W   = CNT_W + SQ_W;
	localparam int VAR_W  = SQ_W;
	localparam int COST_W = S2_W + 1;

	// Binary output levels.
	localparam logic [7:0] PIX_LO = 8'd0;
	localparam logic [7:0] PIX_HI = 8'd255;

	// Request codes.
	localparam logic REQ_COUNT    = 1'b0;
	localparam logic REQ_BINARIZE = 1'b1;

	// Datapath operation codes, one per cycle.
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
	localparam logic [OP_W-1:0] OP_BIN       = 5'd1;
	localparam logic [OP_W-1:0] OP_LATCH     = 5'd2;
	localparam logic [OP_W-1:0] OP_CNT_RD    = 5'd3;
	localparam logic [OP_W-1:0] OP_CNT_WR    = 5'd4;
	localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd5;
	localparam logic [OP_W-1:0] OP_SCAN_RD   = 5'd6;
	localparam logic [OP_W-1:0] OP_SCAN_ACC  = 5'd7;
	localparam logic [OP_W-1:0] OP_SWP_INIT  = 5'd8;
	localparam logic [OP_W-1:0] OP_SWP_RD    = 5'd9;
	localparam logic [OP_W-1:0] OP_SWP_ACC   = 5'd10;
	localparam logic [OP_W-1:0] OP_NEXT      = 5'd11;
	localparam logic [OP_W-1:0] OP_DIV_M_GO  = 5'd12;
	localparam logic [OP_W-1:0] OP_M_TAKE    = 5'd13;
	localparam logic [OP_W-1:0] OP_MUL1      = 5'd14;
	localparam logic [OP_W-1:0] OP_MUL2      = 5'd15;
	localparam logic [OP_W-1:0] OP_SUBV      = 5'd16;
	localparam logic [OP_W-1:0] OP_DIV_V_GO  = 5'd17;
	localparam logic [OP_W-1:0] OP_V_TAKE    = 5'd18;
	localparam logic [OP_W-1:0] OP_MULW      = 5'd19;
	localparam logic [OP_W-1:0] OP_ACCW      = 5'd20;
	localparam logic [OP_W-1:0] OP_CMP       = 5'd21;
	localparam logic [OP_W-1:0] OP_CLR_INIT  = 5'd22;
	localparam logic [OP_W-1:0] OP_CLR       = 5'd23;
	localparam logic [OP_W-1:0] OP_FINISH    = 5'd24;

	typedef struct packed {
		logic             req_type;
		logic [LVL_W-1:0] pixel;
		logic             last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       binary_pixel;
		logic [LVL_W-1:0] threshold;
		logic             threshold_ready;
	} out_item_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic is_last;
		logic addr_end;
		logic swp_end;
		logic eval;
		logic no_cand;
		logic div_done;
		logic cls_b;
	} sts_t;

endpackage

[sv/tile_otsu_threshold_binarizer_top.sv]
// Usage:
// An item is taken at a rising edge where start is high and busy is low; its
// fields arrive on req. Each item gives exactly one result beat on rsp, shown
// for one cycle with rsp_valid high; the receiver cannot stall it.
// A binarize item yields its beat on the next cycle and keeps busy low, so
// binarize items may follow every cycle.
// A count item reads its histogram bin, then writes it back saturated; busy
// is high during the read and the write, and the beat follows the write.
// A count item marked last starts the search: a scan for the occupied range
// and moment sums, then a prefix sweep over the levels up to the last
// candidate. Each candidate adds two class evaluations, each with two
// divisions on the shared serial divider (a mean and a variance; S2_W is
// 37), and one compare. When the occupied range spans fewer than four
// levels the sweep is skipped. A clearing pass follows, then the beat with
// the new threshold and threshold_ready high.
// After reset the histogram is cleared with busy high.
// Depends on otsu_pkg, otsu_ctrl and otsu_dp.
module tile_otsu_threshold_binarizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  otsu_pkg::in_item_t  req,
	output logic                busy,
	output logic                rsp_valid,
	output otsu_pkg::out_item_t rsp
);

	otsu_pkg::cmd_t cmd;
	otsu_pkg::sts_t sts;

	// Sequencer.
	otsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Histogram and arithmetic.
	otsu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

[sv/otsu_div.sv]
// Restoring divider, one quotient bit per cycle, for class means and variances.
// Depends on otsu_pkg for the operand widths.
module otsu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [otsu_pkg::S2_W-1:0]   num,
	input  logic [otsu_pkg::CNT_W-1:0]  den,
	output logic                        done,
	output logic [otsu_pkg::S2_W-1:0]   quo
);

	localparam int NUM_W = otsu_pkg::S2_W;
	localparam int DW    = otsu_pkg::CNT_W;
	localparam int CW    = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      diff;

	// Shift in the next dividend bit and try one subtraction.
	assign rem_sh = {rem_q, nq_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !go && (cnt_q == CW'(1));
			if (go) begin
				cnt_q <= CW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Quotient bits replace dividend bits in the same shift register.
	always_ff @(posedge clk) begin
		if (go) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				nq_q  <= {nq_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				nq_q  <= {nq_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

[sv/otsu_dp.sv]
// Datapath: histogram memory, moment sums, candidate cost evaluation and result register.
// Depends on otsu_pkg and instantiates otsu_div.
module otsu_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  otsu_pkg::cmd_t      cmd,
	input  otsu_pkg::in_item_t  req,
	output otsu_pkg::sts_t      sts,
	output logic                rsp_valid,
	output otsu_pkg::out_item_t rsp
);

	localparam int LVL_W  = otsu_pkg::LVL_W;
	localparam int BIN_W  = otsu_pkg::BIN_W;
	localparam int CNT_W  = otsu_pkg::CNT_W;
	localparam int SQ_W   = otsu_pkg::SQ_W;
	localparam int S1_W   = otsu_pkg::S1_W;
	localparam int S2_W   = otsu_pkg::S2_W;
	localparam int VAR_W  = otsu_pkg::VAR_W;
	localparam int COST_W = otsu_pkg::COST_W;

	// Histogram memory.
	logic [BIN_W-1:0] mem [otsu_pkg::GRAY_LEVELS];
	logic [BIN_W-1:0] rd_q;
	logic             rd_en;
	logic             wr_en;
	logic [LVL_W-1:0] mem_addr;
	logic [BIN_W-1:0] wr_data;

	// Item and sweep state.
	logic [LVL_W-1:0] pix_q;
	logic             last_q;
	logic [LVL_W-1:0] addr_q;
	logic [SQ_W-1:0]  sq_q;
	logic [LVL_W-1:0] l_q;
	logic [LVL_W-1:0] h_q;
	logic             found_l_q;

	// Totals and prefix sums.
	logic [CNT_W-1:0] n_tot_q;
	logic [S1_W-1:0]  s1_tot_q;
	logic [S2_W-1:0]  s2_tot_q;
	logic [CNT_W-1:0] n_a_q;
	logic [S1_W-1:0]  s1_a_q;
	logic [S2_W-1:0]  s2_a_q;

	// Candidate evaluation.
	logic              cls_q;
	logic [LVL_W-1:0]  m_q;
	logic [S1_W+LVL_W-1:0] p1_q;
	logic [SQ_W-1:0]   p2_q;
	logic [S2_W-1:0]   p3_q;
	logic [S2_W-1:0]   vnum_q;
	logic [VAR_W-1:0]  var_q;
	logic [S2_W-1:0]   w_q;
	logic [S2_W-1:0]   costa_q;
	logic [COST_W-1:0] best_q;
	logic              found_q;
	logic [LVL_W-1:0]  thr_q;
	logic [LVL_W-1:0]  held_q;

	logic              rsp_valid_q;
	otsu_pkg::out_item_t rsp_q;

	logic [CNT_W-1:0]  n_x;
	logic [S1_W-1:0]   s1_x;
	logic [S2_W-1:0]   s2_x;
	logic [S2_W+1:0]   vnum_full;
	logic [COST_W-1:0] cost;
	logic              div_go;
	logic [S2_W-1:0]   div_num;
	logic              div_done;
	logic [S2_W-1:0]   div_quo;
	logic [BIN_W-1:0]  bin_inc;
	logic [LVL_W:0]    l_plus3;

	// Class operands: class A is the prefix, class B the remainder of the totals.
	always_comb begin
		if (cls_q) begin
			n_x  = n_tot_q - n_a_q;
			s1_x = s1_tot_q - s1_a_q;
			s2_x = s2_tot_q - s2_a_q;
		end else begin
			n_x  = n_a_q;
			s1_x = s1_a_q;
			s2_x = s2_a_q;
		end
	end

	// Sum of squared deviations: S2 - 2*m*S1 + m*m*n.
	assign vnum_full = {2'b00, s2_x} + {2'b00, p3_q}
		- {{(S2_W + 1 - (S1_W + LVL_W)){1'b0}}, p1_q, 1'b0};
	assign cost      = {1'b0, costa_q} + {1'b0, w_q};
	assign bin_inc   = (rd_q < otsu_pkg::BIN_MAX) ? rd_q + 1'b1 : rd_q;
	assign l_plus3   = {1'b0, l_q} + (LVL_W+1)'(3);

	// Memory port control.
	always_comb begin
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		mem_addr = addr_q;
		wr_data  = '0;
		case (cmd.op) inside
			otsu_pkg::OP_CNT_RD: begin
				rd_en    = 1'b1;
				mem_addr = pix_q;
			end
			otsu_pkg::OP_CNT_WR: begin
				wr_en    = 1'b1;
				mem_addr = pix_q;
				wr_data  = bin_inc;
			end
			otsu_pkg::OP_SCAN_RD, otsu_pkg::OP_SWP_RD: begin
				rd_en = 1'b1;
			end
			otsu_pkg::OP_CLR: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[mem_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Divider operand selection: mean from S1, variance from the deviation sum.
	assign div_go  = (cmd.op == otsu_pkg::OP_DIV_M_GO) || (cmd.op == otsu_pkg::OP_DIV_V_GO);
	assign div_num = (cmd.op == otsu_pkg::OP_DIV_M_GO) ? S2_W'(s1_x) : vnum_q;

	otsu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (n_x),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Result strobe: one beat for a binarize item, a plain count or a search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (cmd.op == otsu_pkg::OP_BIN) || (cmd.op == otsu_pkg::OP_FINISH)
				|| ((cmd.op == otsu_pkg::OP_CNT_WR) && !last_q);
		end
	end

	// Control registers of the sweeps and the held threshold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			found_l_q   <= 1'b0;
			found_q     <= 1'b0;
			cls_q       <= 1'b0;
			held_q      <= '0;
		end else begin
			case (cmd.op)
				otsu_pkg::OP_SCAN_INIT: begin
					addr_q    <= '0;
					found_l_q <= 1'b0;
				end
				otsu_pkg::OP_SCAN_ACC: begin
					addr_q <= addr_q + 1'b1;
					if (rd_q != '0) begin
						found_l_q <= 1'b1;
					end
				end
				otsu_pkg::OP_SWP_INIT: begin
					addr_q  <= '0;
					found_q <= 1'b0;
				end
				otsu_pkg::OP_SWP_ACC: begin
					cls_q <= 1'b0;
				end
				otsu_pkg::OP_ACCW: begin
					cls_q <= 1'b1;
				end
				otsu_pkg::OP_CMP: begin
					if (!found_q || cost < best_q) begin
						found_q <= 1'b1;
					end
				end
				otsu_pkg::OP_NEXT: begin
					addr_q <= addr_q + 1'b1;
				end
				otsu_pkg::OP_CLR_INIT: begin
					addr_q <= '0;
				end
				otsu_pkg::OP_CLR: begin
					addr_q <= addr_q + 1'b1;
				end
				otsu_pkg::OP_FINISH: begin
					held_q <= thr_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: sums, products and the result beat.
	always_ff @(posedge clk) begin
		case (cmd.op) inside
			otsu_pkg::OP_BIN: begin
				rsp_q.binary_pixel    <= (req.pixel < held_q) ? otsu_pkg::PIX_LO
					: otsu_pkg::PIX_HI;
				rsp_q.threshold       <= held_q;
				rsp_q.threshold_ready <= 1'b0;
			end
			otsu_pkg::OP_LATCH: begin
				pix_q  <= req.pixel;
				last_q <= req.last;
			end
			otsu_pkg::OP_CNT_WR: begin
				rsp_q.binary_pixel    <= otsu_pkg::PIX_LO;
				rsp_q.threshold       <= held_q;
				rsp_q.threshold_ready <= 1'b0;
			end
			otsu_pkg::OP_SCAN_INIT: begin
				n_tot_q  <= '0;
				s1_tot_q <= '0;
				s2_tot_q <= '0;
				l_q      <= '0;
				h_q      <= '0;
			end
			otsu_pkg::OP_SCAN_RD, otsu_pkg::OP_SWP_RD: begin
				sq_q <= SQ_W'(addr_q) * SQ_W'(addr_q);
			end
			otsu_pkg::OP_SCAN_ACC: begin
				if (rd_q != '0) begin
					if (!found_l_q) begin
						l_q <= addr_q;
					end
					h_q <= addr_q;
				end
				n_tot_q  <= n_tot_q + CNT_W'(rd_q);
				s1_tot_q <= s1_tot_q + S1_W'(addr_q) * S1_W'(rd_q);
				s2_tot_q <= s2_tot_q + S2_W'(sq_q) * S2_W'(rd_q);
			end
			otsu_pkg::OP_SWP_INIT: begin
				n_a_q  <= '0;
				s1_a_q <= '0;
				s2_a_q <= '0;
				thr_q  <= '0;
			end
			otsu_pkg::OP_SWP_ACC: begin
				n_a_q  <= n_a_q + CNT_W'(rd_q);
				s1_a_q <= s1_a_q + S1_W'(addr_q) * S1_W'(rd_q);
				s2_a_q <= s2_a_q + S2_W'(sq_q) * S2_W'(rd_q);
			end
			otsu_pkg::OP_M_TAKE: begin
				m_q <= div_quo[LVL_W-1:0];
			end
			otsu_pkg::OP_MUL1: begin
				p1_q <= (S1_W+LVL_W)'(m_q) * (S1_W+LVL_W)'(s1_x);
				p2_q <= SQ_W'(m_q) * SQ_W'(m_q);
			end
			otsu_pkg::OP_MUL2: begin
				p3_q <= S2_W'(p2_q) * S2_W'(n_x);
			end
			otsu_pkg::OP_SUBV: begin
				vnum_q <= vnum_full[S2_W-1:0];
			end
			otsu_pkg::OP_V_TAKE: begin
				var_q <= div_quo[VAR_W-1:0];
			end
			otsu_pkg::OP_MULW: begin
				w_q <= S2_W'(n_x) * S2_W'(var_q);
			end
			otsu_pkg::OP_ACCW: begin
				costa_q <= w_q;
			end
			otsu_pkg::OP_CMP: begin
				if (!found_q || cost < best_q) begin
					best_q <= cost;
					thr_q  <= addr_q + 1'b1;
				end
			end
			otsu_pkg::OP_FINISH: begin
				rsp_q.binary_pixel    <= otsu_pkg::PIX_LO;
				rsp_q.threshold       <= thr_q;
				rsp_q.threshold_ready <= 1'b1;
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	// Status back to the controller.
	assign sts.is_last  = last_q;
	assign sts.addr_end = (addr_q == {LVL_W{1'b1}});
	assign sts.swp_end  = (addr_q == h_q - LVL_W'(3));
	assign sts.eval     = (addr_q >= l_q);
	assign sts.no_cand  = ({1'b0, h_q} < l_plus3);
	assign sts.div_done = div_done;
	assign sts.cls_b    = cls_q;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/otsu_ctrl.sv]
// Controller: sequences counting, histogram scan, candidate sweep and clearing.
// Depends on otsu_pkg for command and status types.
module otsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  otsu_pkg::in_item_t req,
	input  otsu_pkg::sts_t     sts,
	output otsu_pkg::cmd_t     cmd,
	output logic               busy
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_CNT_RD    = 5'd1;
	localparam logic [4:0] ST_CNT_WR    = 5'd2;
	localparam logic [4:0] ST_SCAN_INIT = 5'd3;
	localparam logic [4:0] ST_SCAN_RD   = 5'd4;
	localparam logic [4:0] ST_SCAN_ACC  = 5'd5;
	localparam logic [4:0] ST_CHECK     = 5'd6;
	localparam logic [4:0] ST_SWP_RD    = 5'd7;
	localparam logic [4:0] ST_SWP_ACC   = 5'd8;
	localparam logic [4:0] ST_NEXT      = 5'd9;
	localparam logic [4:0] ST_DM_GO     = 5'd10;
	localparam logic [4:0] ST_DM_WAIT   = 5'd11;
	localparam logic [4:0] ST_M_TAKE    = 5'd12;
	localparam logic [4:0] ST_MUL1      = 5'd13;
	localparam logic [4:0] ST_MUL2      = 5'd14;
	localparam logic [4:0] ST_SUBV      = 5'd15;
	localparam logic [4:0] ST_DV_GO     = 5'd16;
	localparam logic [4:0] ST_DV_WAIT   = 5'd17;
	localparam logic [4:0] ST_V_TAKE    = 5'd18;
	localparam logic [4:0] ST_MULW      = 5'd19;
	localparam logic [4:0] ST_ACCW      = 5'd20;
	localparam logic [4:0] ST_CMP       = 5'd21;
	localparam logic [4:0] ST_CLR_INIT  = 5'd22;
	localparam logic [4:0] ST_CLR       = 5'd23;
	localparam logic [4:0] ST_FINISH    = 5'd24;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       boot_q;

	// Next state and the datapath operation for this cycle.
	always_comb begin
		state_d = state_q;
		cmd.op  = otsu_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req.req_type == otsu_pkg::REQ_BINARIZE) begin
						cmd.op = otsu_pkg::OP_BIN;
					end else begin
						cmd.op  = otsu_pkg::OP_LATCH;
						state_d = ST_CNT_RD;
					end
				end
			end
			ST_CNT_RD: begin
				cmd.op  = otsu_pkg::OP_CNT_RD;
				state_d = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cmd.op  = otsu_pkg::OP_CNT_WR;
				state_d = sts.is_last ? ST_SCAN_INIT : ST_IDLE;
			end
			ST_SCAN_INIT: begin
				cmd.op  = otsu_pkg::OP_SCAN_INIT;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				cmd.op  = otsu_pkg::OP_SCAN_RD;
				state_d = ST_SCAN_ACC;
			end
			ST_SCAN_ACC: begin
				cmd.op  = otsu_pkg::OP_SCAN_ACC;
				state_d = sts.addr_end ? ST_CHECK : ST_SCAN_RD;
			end
			ST_CHECK: begin
				cmd.op  = otsu_pkg::OP_SWP_INIT;
				state_d = sts.no_cand ? ST_CLR_INIT : ST_SWP_RD;
			end
			ST_SWP_RD: begin
				cmd.op  = otsu_pkg::OP_SWP_RD;
				state_d = ST_SWP_ACC;
			end
			ST_SWP_ACC: begin
				cmd.op  = otsu_pkg::OP_SWP_ACC;
				state_d = sts.eval ? ST_DM_GO : ST_NEXT;
			end
			ST_NEXT: begin
				cmd.op  = otsu_pkg::OP_NEXT;
				state_d = sts.swp_end ? ST_CLR_INIT : ST_SWP_RD;
			end
			ST_DM_GO: begin
				cmd.op  = otsu_pkg::OP_DIV_M_GO;
				state_d = ST_DM_WAIT;
			end
			ST_DM_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_M_TAKE;
				end
			end
			ST_M_TAKE: begin
				cmd.op  = otsu_pkg::OP_M_TAKE;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.op  = otsu_pkg::OP_MUL1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.op  = otsu_pkg::OP_MUL2;
				state_d = ST_SUBV;
			end
			ST_SUBV: begin
				cmd.op  = otsu_pkg::OP_SUBV;
				state_d = ST_DV_GO;
			end
			ST_DV_GO: begin
				cmd.op  = otsu_pkg::OP_DIV_V_GO;
				state_d = ST_DV_WAIT;
			end
			ST_DV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_V_TAKE;
				end
			end
			ST_V_TAKE: begin
				cmd.op  = otsu_pkg::OP_V_TAKE;
				state_d = ST_MULW;
			end
			ST_MULW: begin
				cmd.op  = otsu_pkg::OP_MULW;
				state_d = ST_ACCW;
			end
			ST_ACCW: begin
				// Class A done: go on with class B; class B done: compare.
				if (sts.cls_b) begin
					state_d = ST_CMP;
				end else begin
					cmd.op  = otsu_pkg::OP_ACCW;
					state_d = ST_DM_GO;
				end
			end
			ST_CMP: begin
				cmd.op  = otsu_pkg::OP_CMP;
				state_d = ST_NEXT;
			end
			ST_CLR_INIT: begin
				cmd.op  = otsu_pkg::OP_CLR_INIT;
				state_d = ST_CLR;
			end
			ST_CLR: begin
				cmd.op = otsu_pkg::OP_CLR;
				if (sts.addr_end) begin
					state_d = boot_q ? ST_IDLE : ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.op  = otsu_pkg::OP_FINISH;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Reset starts with a clearing pass over the histogram.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR && sts.addr_end) begin
				boot_q <= 1'b0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
